// ===== rtl/rct_pkg.sv =====
// Shared types, constants and helper functions of the range coalescing table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rct_pkg;

	localparam int ADDR_BITS     = 48;
	localparam int DEPTH_DEFAULT = 16;
	localparam int COUNT_BITS    = 5;
	localparam int QUEUE_DEPTH   = 2;

	typedef logic [ADDR_BITS-1:0] base_t;
	typedef logic [ADDR_BITS:0]   size_t;
	typedef logic [ADDR_BITS+1:0] end_t;
	typedef logic [2:0]           status_t;

	localparam status_t ST_APPEND = 3'd0;
	localparam status_t ST_MERGE1 = 3'd1;
	localparam status_t ST_MERGEN = 3'd2;
	localparam status_t ST_DROP   = 3'd3;
	localparam status_t ST_DUMP   = 3'd4;

	typedef struct packed {
		logic  kind;
		base_t range_base;
		base_t range_size;
	} item_t;

	typedef struct packed {
		status_t               status;
		base_t                 entry_base;
		size_t                 entry_size;
		logic                  entry_valid;
		logic [COUNT_BITS-1:0] entry_count;
		logic                  last;
	} result_t;

	// Command handed from the front to the back through the queue.
	typedef struct packed {
		logic  dump;
		base_t base;
		size_t size;
		end_t  stop;
	} cmd_t;

	// Handshake from the front to the queue; only push and full are driven.
	typedef struct packed {
		logic push;
		logic full;
		logic head_valid;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		base_t base;
		size_t size;
	} span_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CMP,
		B_ACT,
		B_MERGE,
		B_FIN,
		B_DUMP
	} back_state_t;

	function automatic logic overlap(base_t ab, end_t ae, base_t bb, end_t be);
		logic r;
		r = ((end_t'(ab) <= end_t'(bb)) && (end_t'(bb) < ae)) ||
			((end_t'(bb) <= end_t'(ab)) && (end_t'(ab) < be));
		return r;
	endfunction

	// Union of two ranges; the size wraps to its field width.
	function automatic span_t unite(base_t ab, size_t as, base_t bb, size_t bs);
		end_t  e1;
		end_t  e2;
		base_t lo;
		end_t  hi;
		end_t  diff;
		span_t r;
		e1   = end_t'(ab) + end_t'(as);
		e2   = end_t'(bb) + end_t'(bs);
		lo   = (ab < bb) ? ab : bb;
		hi   = (e1 > e2) ? e1 : e2;
		diff = hi - end_t'(lo);
		r.base = lo;
		r.size = diff[ADDR_BITS:0];
		return r;
	endfunction

endpackage

// ===== rtl/range_coalescing_table.sv =====
// Range coalescing table: registered front stage, 2-entry queue, then table back end.
// The back end handles one command at a time: it pops, compares and acts on an insert;
// an insert that merges several entries adds a compaction sweep over the table, and a
// dump emits one transfer per entry (a single one when empty). Reset clears count and queue.
// Depends on rct_pkg, rct_front, rct_queue and rct_back.
`timescale 1ns / 1ps

module range_coalescing_table
	import rct_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	queue_ctl_t qctl;
	logic q_full;
	logic q_head_valid;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t head;

	rct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.qctl       (qctl),
		.q_full     (q_full),
		.cmd        (push_cmd)
	);

	rct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (qctl.push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.head       (head)
	);

	rct_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head         (head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/rct_front.sv =====
// Front part: takes input transfers, decodes the kind and precomputes the range end.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_front
	import rct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output queue_ctl_t qctl,
	input  logic       q_full,
	output cmd_t       cmd
);

	logic cmd_valid_q;
	cmd_t cmd_q;
	logic accept;

	assign item_stall = cmd_valid_q && q_full;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		qctl            = '0;
		qctl.push       = cmd_valid_q && !q_full;
		qctl.full       = q_full;
	end

	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else begin
			cmd_valid_q <= accept || (cmd_valid_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.dump <= item.kind;
			cmd_q.base <= item.range_base;
			cmd_q.size <= {1'b0, item.range_size};
			cmd_q.stop <= end_t'(item.range_base) + end_t'(item.range_size);
		end
	end

endmodule

// ===== rtl/rct_queue.sv =====
// Short command queue that decouples the front from the back.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_queue
	import rct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	input  logic pop,
	output cmd_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] fill_q;

	assign full       = (fill_q == CW'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_q];

	function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/rct_back.sv =====
// Back part: holds the range table, compares, widens, compacts and dumps entries.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_back
	import rct_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	base_t base_q [TABLE_DEPTH];
	size_t size_q [TABLE_DEPTH];
	logic [CW-1:0] count_q;

	back_state_t state_q;
	back_state_t state_d;
	cmd_t    cur_q;
	logic [TABLE_DEPTH-1:0] mask_q;
	logic [TABLE_DEPTH-1:0] mask_d;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] wr_q;
	base_t   acc_base_q;
	size_t   acc_size_q;
	logic    rv_q;
	result_t res_q;

	logic    out_free;
	logic    hit_none;
	logic    hit_one;
	logic    n_full;
	logic    idx_last;
	logic [CW-1:0] count_m1;
	base_t   sel_base;
	size_t   sel_size;
	base_t   rd_base;
	size_t   rd_size;
	span_t   uni_one;
	span_t   uni_acc;

	logic    tbl_we;
	logic [IW-1:0] tbl_addr;
	base_t   tbl_base;
	size_t   tbl_size;
	logic    cnt_we;
	logic [CW-1:0] cnt_d;
	logic    emit;
	result_t emit_res;
	logic    acc_init;
	logic    acc_upd;
	logic    idx_clr;
	logic    idx_inc;
	logic    wr_inc;
	logic    mask_ld;

	assign out_free     = !rv_q || !result_stall;
	assign result_valid = rv_q;
	assign result       = res_q;

	assign hit_none = (mask_q == '0);
	assign hit_one  = $onehot(mask_q);
	assign n_full   = (count_q == CW'(TABLE_DEPTH));
	assign count_m1 = count_q - 1'b1;
	assign idx_last = (idx_q == count_m1[IW-1:0]);
	assign rd_base  = base_q[idx_q];
	assign rd_size  = size_q[idx_q];

	// Parallel overlap test of every live entry against the new range.
	always_comb begin
		end_t se;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			se        = end_t'(base_q[k]) + end_t'(size_q[k]);
			mask_d[k] = (CW'(k) < count_q) && overlap(base_q[k], se, cur_q.base, cur_q.stop);
		end
	end

	// With exactly one hit, the AND-OR picks that entry.
	always_comb begin
		sel_base = '0;
		sel_size = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			sel_base = sel_base | (base_q[k] & {ADDR_BITS{mask_q[k]}});
			sel_size = sel_size | (size_q[k] & {(ADDR_BITS + 1){mask_q[k]}});
		end
	end

	assign uni_one = unite(cur_q.base, cur_q.size, sel_base, sel_size);
	assign uni_acc = unite(acc_base_q, acc_size_q, rd_base, rd_size);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					state_d = head.dump ? B_DUMP : B_CMP;
				end
			end
			B_CMP: begin
				state_d = B_ACT;
			end
			B_ACT: begin
				if (hit_none || hit_one) begin
					if (out_free) begin
						state_d = B_IDLE;
					end
				end else begin
					state_d = B_MERGE;
				end
			end
			B_MERGE: begin
				if (idx_last) begin
					state_d = B_FIN;
				end
			end
			B_FIN: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_DUMP: begin
				if (out_free && ((count_q == '0) || idx_last)) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		tbl_we   = 1'b0;
		tbl_addr = '0;
		tbl_base = '0;
		tbl_size = '0;
		cnt_we   = 1'b0;
		cnt_d    = count_q;
		emit     = 1'b0;
		emit_res = '0;
		acc_init = 1'b0;
		acc_upd  = 1'b0;
		idx_clr  = 1'b0;
		idx_inc  = 1'b0;
		wr_inc   = 1'b0;
		mask_ld  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop     = head_valid;
				idx_clr = head_valid;
			end
			B_CMP: begin
				mask_ld = 1'b1;
			end
			B_ACT: begin
				if (hit_none) begin
					emit = out_free;
					emit_res.last = 1'b1;
					if (n_full) begin
						emit_res.status      = ST_DROP;
						emit_res.entry_count = COUNT_BITS'(count_q);
					end else begin
						tbl_we   = out_free;
						tbl_addr = count_q[IW-1:0];
						tbl_base = cur_q.base;
						tbl_size = cur_q.size;
						cnt_we   = out_free;
						cnt_d    = count_q + 1'b1;
						emit_res.status      = ST_APPEND;
						emit_res.entry_base  = cur_q.base;
						emit_res.entry_size  = cur_q.size;
						emit_res.entry_valid = 1'b1;
						emit_res.entry_count = COUNT_BITS'(count_q + 1'b1);
					end
				end else if (hit_one) begin
					tbl_we = out_free;
					for (int k = 0; k < TABLE_DEPTH; k++) begin
						if (mask_q[k]) begin
							tbl_addr = IW'(k);
						end
					end
					tbl_base = uni_one.base;
					tbl_size = uni_one.size;
					emit     = out_free;
					emit_res.status      = ST_MERGE1;
					emit_res.entry_base  = uni_one.base;
					emit_res.entry_size  = uni_one.size;
					emit_res.entry_valid = 1'b1;
					emit_res.entry_count = COUNT_BITS'(count_q);
					emit_res.last        = 1'b1;
				end else begin
					acc_init = 1'b1;
					idx_clr  = 1'b1;
				end
			end
			B_MERGE: begin
				idx_inc = 1'b1;
				if (mask_q[idx_q]) begin
					acc_upd = 1'b1;
				end else begin
					// Entries that survive slide down over the merged ones.
					tbl_we   = 1'b1;
					tbl_addr = wr_q;
					tbl_base = rd_base;
					tbl_size = rd_size;
					wr_inc   = 1'b1;
				end
			end
			B_FIN: begin
				tbl_we   = out_free;
				tbl_addr = wr_q;
				tbl_base = acc_base_q;
				tbl_size = acc_size_q;
				cnt_we   = out_free;
				cnt_d    = CW'(wr_q) + 1'b1;
				emit     = out_free;
				emit_res.status      = ST_MERGEN;
				emit_res.entry_base  = acc_base_q;
				emit_res.entry_size  = acc_size_q;
				emit_res.entry_valid = 1'b1;
				emit_res.entry_count = COUNT_BITS'(CW'(wr_q) + 1'b1);
				emit_res.last        = 1'b1;
			end
			B_DUMP: begin
				emit    = out_free;
				idx_inc = out_free;
				emit_res.status      = ST_DUMP;
				emit_res.entry_count = COUNT_BITS'(count_q);
				if (count_q == '0) begin
					emit_res.last = 1'b1;
				end else begin
					emit_res.entry_base  = rd_base;
					emit_res.entry_size  = rd_size;
					emit_res.entry_valid = 1'b1;
					emit_res.last        = idx_last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				count_q <= cnt_d;
			end
			if (emit) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (mask_ld) begin
			mask_q <= mask_d;
		end
		if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (acc_init) begin
			wr_q       <= '0;
			acc_base_q <= cur_q.base;
			acc_size_q <= cur_q.size;
		end else begin
			if (wr_inc) begin
				wr_q <= wr_q + 1'b1;
			end
			if (acc_upd) begin
				acc_base_q <= uni_acc.base;
				acc_size_q <= uni_acc.size;
			end
		end
		if (tbl_we) begin
			base_q[tbl_addr] <= tbl_base;
			size_q[tbl_addr] <= tbl_size;
		end
		if (emit) begin
			res_q <= emit_res;
		end
	end

endmodule

// ===== rtl/rct_checker.sv =====
// Port-level checks of the range coalescing table, bound to the top level.
// Depends on rct_pkg and range_coalescing_table.
`timescale 1ns / 1ps

module rct_checker
	import rct_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled input transfer keeps its payload.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input changed");

	// A stalled result transfer holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Every insert gives exactly one result, so it carries the last mark.
	a_insert_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_DUMP) |-> result.last)
		else $error("insert result without last");

	// A dropped insert only happens on a full table and carries no entry.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_DROP) |->
			!result.entry_valid && (result.entry_count == COUNT_BITS'(TABLE_DEPTH)))
		else $error("drop on a table that is not full");

	// A result without an entry is either a drop or the single empty-dump transfer.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.entry_valid |->
			result.last && (result.entry_base == '0) && (result.entry_size == '0))
		else $error("empty result malformed");

endmodule

bind range_coalescing_table rct_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_rct_checker (.*);
